FILE: hw/rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// Mouse packet decoder package
// Shared types and constants for the mouse packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

	// Header bits: overflow flags and button bits.
	localparam int unsigned HDR_OVF_Y  = 7;
	localparam int unsigned HDR_OVF_X  = 6;
	localparam int unsigned BTN_MIDDLE = 2;
	localparam int unsigned BTN_RIGHT  = 1;
	localparam int unsigned BTN_LEFT   = 0;

	localparam int unsigned BTN_COUNT  = 3;

	// Default depth of the packet queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	// Position of the next byte within a three-byte packet.
	typedef enum logic [1:0] {
		POS_HEADER = 2'd0,
		POS_X      = 2'd1,
		POS_Y      = 2'd2
	} pos_t;

	// One complete, non-overflow packet.
	typedef struct packed {
		logic [BTN_COUNT-1:0] buttons;
		logic [7:0]           x;
		logic [7:0]           y;
	} pkt_t;

	// Queue handshake as seen from the writer and the reader.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage : mpd_pkg

`default_nettype wire

FILE: hw/rtl/mpd_front.sv
// ----------------------------------------------------------------------------
// Mouse packet decoder front
// Counts bytes into packets, drops overflow packets, writes good ones to queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [7:0]    data_byte,
	input  wire logic          q_full,
	output logic               full,
	output logic               wr_en,
	output mpd_pkg::pkt_t      wr_pkt
);

	mpd_pkg::pos_t pos_q;
	logic [7:0]    header_q;
	logic [7:0]    x_q;
	logic          accept;
	logic          last_byte;
	logic          overflow;

	assign full      = q_full;
	assign accept    = push & ~q_full;
	assign last_byte = (pos_q != mpd_pkg::POS_HEADER) && (pos_q != mpd_pkg::POS_X);
	assign overflow  = header_q[mpd_pkg::HDR_OVF_Y] | header_q[mpd_pkg::HDR_OVF_X];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= mpd_pkg::POS_HEADER;
		end else if (accept) begin
			case (pos_q)
				mpd_pkg::POS_HEADER: begin
					pos_q <= mpd_pkg::POS_X;
				end
				mpd_pkg::POS_X: begin
					pos_q <= mpd_pkg::POS_Y;
				end
				default: begin
					pos_q <= mpd_pkg::POS_HEADER;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (pos_q == mpd_pkg::POS_HEADER)) begin
			header_q <= data_byte;
		end
		if (accept && (pos_q == mpd_pkg::POS_X)) begin
			x_q <= data_byte;
		end
	end

	// Drop the packet when either overflow flag is set.
	assign wr_en          = accept & last_byte & ~overflow;
	assign wr_pkt.buttons = header_q[mpd_pkg::BTN_COUNT-1:0];
	assign wr_pkt.x       = x_q;
	assign wr_pkt.y       = data_byte;

endmodule : mpd_front

`default_nettype wire

FILE: hw/rtl/mpd_queue.sv
// ----------------------------------------------------------------------------
// Mouse packet decoder queue
// Short packet queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_queue #(
	parameter int unsigned DEPTH = mpd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire mpd_pkg::pkt_t wr_pkt,
	input  wire logic          rd_en,
	output mpd_pkg::pkt_t      rd_pkt,
	output mpd_pkg::q_status_t status
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	mpd_pkg::pkt_t    slots_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign status.full  = (count_q == FullCnt);
	assign status.empty = (count_q == '0);
	assign do_wr        = wr_en & ~status.full;
	assign do_rd        = rd_en & ~status.empty;
	assign rd_pkt       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_pkt;
		end
	end

endmodule : mpd_queue

`default_nettype wire

FILE: hw/rtl/mpd_back.sv
// ----------------------------------------------------------------------------
// Mouse packet decoder back
// Derives button edges against the last packet and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mpd_pkg::pkt_t          rd_pkt,
	input  wire logic                   q_empty,
	output logic                        rd_en,
	input  wire logic                   pop,
	output logic                        empty,
	output logic signed [7:0]           delta_x,
	output logic signed [7:0]           delta_y,
	output logic [mpd_pkg::BTN_COUNT-1:0] down,
	output logic [mpd_pkg::BTN_COUNT-1:0] pressed,
	output logic [mpd_pkg::BTN_COUNT-1:0] released
);

	logic                         out_valid_q;
	logic [mpd_pkg::BTN_COUNT-1:0] last_buttons_q;
	logic [7:0]                   x_q;
	logic [7:0]                   y_q;
	logic [mpd_pkg::BTN_COUNT-1:0] down_q;
	logic [mpd_pkg::BTN_COUNT-1:0] pressed_q;
	logic [mpd_pkg::BTN_COUNT-1:0] released_q;

	// Advance when a packet waits and the result register is free or drains.
	assign rd_en = ~q_empty & (~out_valid_q | pop);
	assign empty = ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			last_buttons_q <= '0;
		end else begin
			if (rd_en) begin
				out_valid_q    <= 1'b1;
				last_buttons_q <= rd_pkt.buttons;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			x_q        <= rd_pkt.x;
			y_q        <= rd_pkt.y;
			down_q     <= rd_pkt.buttons;
			pressed_q  <= rd_pkt.buttons & ~last_buttons_q;
			released_q <= last_buttons_q & ~rd_pkt.buttons;
		end
	end

	assign delta_x  = signed'(x_q);
	assign delta_y  = signed'(y_q);
	assign down     = down_q;
	assign pressed  = pressed_q;
	assign released = released_q;

endmodule : mpd_back

`default_nettype wire

FILE: hw/rtl/mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// Mouse packet decoder
// Groups raw mouse bytes into three-byte packets and reports movement and
// button state with press and release edges.
//
// Input channel: a beat is taken when push is high and full is low; one
// data_byte per beat, one beat per cycle sustained while full stays low.
// Bytes count header, X, Y; on the Y byte a packet with either overflow
// flag set in its header is dropped and leaves the button history alone.
// Result channel: while empty is low the oldest result is on the ports; a
// pop with empty low takes it. Empty goes low once the Y byte's packet
// is through: the front writes the packet queue at that beat's edge and
// the back loads it into the result register when that is free or popped.
// One result per non-overflow packet, so at most one per three input beats.
// Stall: a held result stalls the back; the packet queue keeps taking
// packets until it fills, then full rises and input beats wait.
// Reset: arst_n clears the byte position, the button history (all up),
// the queue and the result valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_packet_decoder #(
	parameter int unsigned QUEUE_DEPTH = mpd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic signed [7:0] delta_x,
	output logic signed [7:0] delta_y,
	output logic             left_down,
	output logic             middle_down,
	output logic             right_down,
	output logic             left_pressed,
	output logic             middle_pressed,
	output logic             right_pressed,
	output logic             left_released,
	output logic             middle_released,
	output logic             right_released
);

	mpd_pkg::pkt_t      wr_pkt;
	mpd_pkg::pkt_t      rd_pkt;
	mpd_pkg::q_status_t q_status;
	logic               wr_en;
	logic               rd_en;
	logic [mpd_pkg::BTN_COUNT-1:0] down;
	logic [mpd_pkg::BTN_COUNT-1:0] pressed;
	logic [mpd_pkg::BTN_COUNT-1:0] released;

	// Front: count bytes, hold header and X, drop overflow packets.
	mpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.q_full    (q_status.full),
		.full      (full),
		.wr_en     (wr_en),
		.wr_pkt    (wr_pkt)
	);

	// Queue: decouple packet assembly from result delivery.
	mpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_pkt (wr_pkt),
		.rd_en  (rd_en),
		.rd_pkt (rd_pkt),
		.status (q_status)
	);

	// Back: edges against the last accepted packet, result register.
	mpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_pkt   (rd_pkt),
		.q_empty  (q_status.empty),
		.rd_en    (rd_en),
		.pop      (pop),
		.empty    (empty),
		.delta_x  (delta_x),
		.delta_y  (delta_y),
		.down     (down),
		.pressed  (pressed),
		.released (released)
	);

	assign left_down       = down[mpd_pkg::BTN_LEFT];
	assign middle_down     = down[mpd_pkg::BTN_MIDDLE];
	assign right_down      = down[mpd_pkg::BTN_RIGHT];
	assign left_pressed    = pressed[mpd_pkg::BTN_LEFT];
	assign middle_pressed  = pressed[mpd_pkg::BTN_MIDDLE];
	assign right_pressed   = pressed[mpd_pkg::BTN_RIGHT];
	assign left_released   = released[mpd_pkg::BTN_LEFT];
	assign middle_released = released[mpd_pkg::BTN_MIDDLE];
	assign right_released  = released[mpd_pkg::BTN_RIGHT];

endmodule : mouse_packet_decoder

`default_nettype wire

FILE: verif/mpd_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse packet decoder scoreboard
// Tracks packet framing and button history from the accepted input beats,
// keeps the reports each complete packet should produce, and matches them
// in order against the reports the decoder hands out.
// ----------------------------------------------------------------------------

package mpd_tb_pkg;

	// One movement report; button vectors use the header bit positions.
	typedef struct packed {
		logic [7:0]                    dx;
		logic [7:0]                    dy;
		logic [mpd_pkg::BTN_COUNT-1:0] held;
		logic [mpd_pkg::BTN_COUNT-1:0] pressed;
		logic [mpd_pkg::BTN_COUNT-1:0] released;
	} mouse_report_t;

	class packet_report_board;
		mpd_pkg::pos_t                 next_pos;
		logic [7:0]                    header;
		logic [7:0]                    x_move;
		logic [mpd_pkg::BTN_COUNT-1:0] prev_buttons;
		mouse_report_t                 due_reports[$];
		int unsigned                   errors;

		function new();
			next_pos     = mpd_pkg::POS_HEADER;
			header       = '0;
			x_move       = '0;
			prev_buttons = '0;
			errors       = 0;
		endfunction

		// Advance the packet framing by one accepted byte.
		function void take_byte(logic [7:0] b);
			mouse_report_t rpt;
			case (next_pos)
				mpd_pkg::POS_HEADER: begin
					header   = b;
					next_pos = mpd_pkg::POS_X;
				end
				mpd_pkg::POS_X: begin
					x_move   = b;
					next_pos = mpd_pkg::POS_Y;
				end
				default: begin
					next_pos = mpd_pkg::POS_HEADER;
					// Drop overflow packets without touching the button history.
					if (!header[mpd_pkg::HDR_OVF_Y] && !header[mpd_pkg::HDR_OVF_X]) begin
						rpt.dx       = x_move;
						rpt.dy       = b;
						rpt.held     = header[mpd_pkg::BTN_COUNT-1:0];
						rpt.pressed  = rpt.held & ~prev_buttons;
						rpt.released = prev_buttons & ~rpt.held;
						prev_buttons = rpt.held;
						due_reports.push_back(rpt);
					end
				end
			endcase
		endfunction

		function void compare(string name, int want, int seen);
			if (want != seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void match_report(mouse_report_t got);
			mouse_report_t want;
			if (due_reports.size() == 0) begin
				$error("report with no packet waiting: dx %0d dy %0d",
					$signed(got.dx), $signed(got.dy));
				errors++;
				return;
			end
			want = due_reports.pop_front();
			compare("delta_x", $signed(want.dx), $signed(got.dx));
			compare("delta_y", $signed(want.dy), $signed(got.dy));
			compare("left_down", want.held[mpd_pkg::BTN_LEFT],
				got.held[mpd_pkg::BTN_LEFT]);
			compare("middle_down", want.held[mpd_pkg::BTN_MIDDLE],
				got.held[mpd_pkg::BTN_MIDDLE]);
			compare("right_down", want.held[mpd_pkg::BTN_RIGHT],
				got.held[mpd_pkg::BTN_RIGHT]);
			compare("left_pressed", want.pressed[mpd_pkg::BTN_LEFT],
				got.pressed[mpd_pkg::BTN_LEFT]);
			compare("middle_pressed", want.pressed[mpd_pkg::BTN_MIDDLE],
				got.pressed[mpd_pkg::BTN_MIDDLE]);
			compare("right_pressed", want.pressed[mpd_pkg::BTN_RIGHT],
				got.pressed[mpd_pkg::BTN_RIGHT]);
			compare("left_released", want.released[mpd_pkg::BTN_LEFT],
				got.released[mpd_pkg::BTN_LEFT]);
			compare("middle_released", want.released[mpd_pkg::BTN_MIDDLE],
				got.released[mpd_pkg::BTN_MIDDLE]);
			compare("right_released", want.released[mpd_pkg::BTN_RIGHT],
				got.released[mpd_pkg::BTN_RIGHT]);
		endfunction

		function int unsigned reports_due();
			return due_reports.size();
		endfunction
	endclass

endpackage : mpd_tb_pkg

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse packet decoder testbench
// Streams raw mouse bytes into the decoder, first a handful of hand-picked
// packets, then random packets under three idling mixes and one long
// receiver hold-off, and checks every movement report in order.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int unsigned CLK_PERIOD      = 2;
	localparam int unsigned RESET_CYCLES    = 7;
	// Random packets per idling phase; three phases plus the directed set
	// come to roughly 1950 bytes.
	localparam int unsigned PHASE_PACKETS   = 214;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	// Slack at the end once no report is still due.
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned STALL_LIMIT     = 5000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              push      = 1'b0;
	logic [7:0]        data_byte = '0;
	logic              pop       = 1'b0;
	logic              full;
	logic              empty;
	logic signed [7:0] delta_x;
	logic signed [7:0] delta_y;
	logic              left_down;
	logic              middle_down;
	logic              right_down;
	logic              left_pressed;
	logic              middle_pressed;
	logic              right_pressed;
	logic              left_released;
	logic              middle_released;
	logic              right_released;

	// Idling odds in percent per cycle; main sets them per phase.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	// Raised by main to make the receiver stop popping for a long stretch.
	bit          hold_off_req  = 1'b0;

	mpd_tb_pkg::packet_report_board board;

	mouse_packet_decoder dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one byte; idle first at random, then hold the beat until taken.
	// All samples right after the edge see the values that edge acted on.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x_mv,
		input logic [7:0] y_mv);
		send_byte(hdr);
		send_byte(x_mv);
		send_byte(y_mv);
	endtask

	// Mostly clean headers so the button history gets exercised; the rest
	// keeps fully random headers, overflow flags included.
	task automatic send_random_packet();
		logic [7:0] hdr;
		hdr = 8'($urandom_range(255));
		if ($urandom_range(99) < 80) begin
			hdr[mpd_pkg::HDR_OVF_Y] = 1'b0;
			hdr[mpd_pkg::HDR_OVF_X] = 1'b0;
		end
		send_packet(hdr, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// Receiver: pop at random each cycle, or hold off on request.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Monitor: feed accepted input beats to the scoreboard and check every
	// accepted result beat against the oldest report due.
	always @(posedge clk) begin : monitor
		mpd_tb_pkg::mouse_report_t seen;
		if (arst_n) begin
			if (push && !full)
				board.take_byte(data_byte);
			if (pop && !empty) begin
				seen.dx                            = delta_x;
				seen.dy                            = delta_y;
				seen.held[mpd_pkg::BTN_LEFT]       = left_down;
				seen.held[mpd_pkg::BTN_MIDDLE]     = middle_down;
				seen.held[mpd_pkg::BTN_RIGHT]      = right_down;
				seen.pressed[mpd_pkg::BTN_LEFT]    = left_pressed;
				seen.pressed[mpd_pkg::BTN_MIDDLE]  = middle_pressed;
				seen.pressed[mpd_pkg::BTN_RIGHT]   = right_pressed;
				seen.released[mpd_pkg::BTN_LEFT]   = left_released;
				seen.released[mpd_pkg::BTN_MIDDLE] = middle_released;
				seen.released[mpd_pkg::BTN_RIGHT]  = right_released;
				board.match_report(seen);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : main
		int unsigned phase;
		board = new();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed packets, first idling mix.
		send_idle_pct = 8;
		recv_idle_pct = 60;
		send_packet(8'h00, 8'h00, 8'h00);   // all up, zero movement
		send_packet(8'h07, 8'h7F, 8'h80);   // all pressed, max positive / min negative
		send_packet(8'h38, 8'h80, 8'h7F);   // spare header bits only, all released
		send_packet(8'hC7, 8'hFF, 8'hFF);   // both overflow flags: drop
		send_packet(8'h81, 8'h01, 8'h01);   // Y overflow: drop, history kept
		send_packet(8'h42, 8'h02, 8'hFE);   // X overflow: drop
		send_packet(8'h05, 8'hFF, 8'h00);   // left and middle pressed
		send_packet(8'h3A, 8'h55, 8'hAA);   // right pressed, left and middle released

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 8;
				end
				default: begin
					// Full rate both ways; stall the receiver so the queue
					// fills and full pushes back on the input.
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_off_req  = 1'b1;
				end
			endcase
			repeat (PHASE_PACKETS) send_random_packet();
		end
		push <= 1'b0;

		// Drain: wait for every due report, then allow for the pipeline.
		@(posedge clk);
		while (board.reports_due() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.reports_due() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule : tb_top

FILE: files.f
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_front.sv
hw/rtl/mpd_queue.sv
hw/rtl/mpd_back.sv
hw/rtl/mouse_packet_decoder.sv
verif/mpd_tb_pkg.sv
verif/tb_top.sv
